/* hdl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// types and constants shared by the bitmap page allocator modules
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	typedef enum logic [1:0] {
		ACT_ALLOC     = 2'd0,
		ACT_MARK_USED = 2'd1,
		ACT_MARK_FREE = 2'd2,
		ACT_QUERY     = 2'd3
	} bpa_action_t;

	typedef enum logic {
		CFG_SEARCH_START = 1'b0,
		CFG_USABLE_LIMIT = 1'b1
	} bpa_cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_QRY_RD,
		ST_QRY_CHK,
		ST_DONE
	} bpa_state_t;

	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] hit_pos;
		logic [BIT_W:0]   pop;
	} bpa_word_stat_t;

	localparam logic [15:0] SEARCH_START_RST = 16'd12288;
	localparam logic [16:0] USABLE_LIMIT_RST = 17'd65536;

endpackage

/* hdl/bpa_req_if.sv */
// ----------------------------------------------------------------------------
// bpa_req_if
// request channel of the page allocator
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] page_index;
	logic [16:0] page_count;

	modport source (output valid, action, page_index, page_count, input ready);
	modport sink   (input valid, action, page_index, page_count, output ready);
endinterface

/* hdl/bpa_rsp_if.sv */
// ----------------------------------------------------------------------------
// bpa_rsp_if
// response channel of the page allocator
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_page;
	logic        success;
	logic        page_used;
	logic [16:0] used_total;

	modport source (output valid, result_page, success, page_used, used_total, input ready);
	modport sink   (input valid, result_page, success, page_used, used_total, output ready);
endinterface

/* hdl/bpa_cfg_if.sv */
// ----------------------------------------------------------------------------
// bpa_cfg_if
// register write channel of the page allocator
// ----------------------------------------------------------------------------
interface bpa_cfg_if;
	logic        valid;
	logic        ready;
	logic        reg_index;
	logic [16:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/bpa_bitmap_ram.sv */
// ----------------------------------------------------------------------------
// bpa_bitmap_ram
// used-bit store, one word of pages per row, registered read
// ----------------------------------------------------------------------------
module bpa_bitmap_ram
	import bpa_pkg::*;
#(
	parameter int ROWS = 2048,
	parameter int RW   = 11
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [RW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [RW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/bpa_word_ops.sv */
// ----------------------------------------------------------------------------
// bpa_word_ops
// per-word logic: free-run search and range set/clear with flip count
// ----------------------------------------------------------------------------
module bpa_word_ops
	import bpa_pkg::*;
#(
	parameter int XW = 18
) (
	input  logic [WORD_W-1:0] data,
	input  logic [XW-1:0]     word_base,
	input  logic [XW-1:0]     start_page,
	input  logic [XW-1:0]     lim_page,
	input  logic [XW-1:0]     run_in,
	input  logic [XW-1:0]     need,
	input  logic              set_mode,
	input  logic              first_row,
	input  logic              last_row,
	input  logic [BIT_W-1:0]  lo_bit,
	input  logic [BIT_W-1:0]  last_bit,
	output bpa_word_stat_t    stat,
	output logic [XW-1:0]     run_out,
	output logic [WORD_W-1:0] new_word
);

	logic [WORD_W-1:0] unusable;
	logic [WORD_W-1:0] hitv;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] flips;
	logic [XW-1:0]     pg;
	logic [XW-1:0]     run_j;
	logic [BIT_W-1:0]  hu;
	logic              any;

	// bits outside [start, limit) behave as used so no run crosses them
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			pg = word_base + XW'(j);
			unusable[j] = data[j] | (pg < start_page) | (pg >= lim_page);
		end
	end

	// run of free pages ending at each bit, carried in from earlier words
	always_comb begin
		run_out = '0;
		for (int j = 0; j < WORD_W; j++) begin
			any = 1'b0;
			hu  = '0;
			for (int k = 0; k <= j; k++) begin
				if (unusable[k]) begin
					any = 1'b1;
					hu  = BIT_W'(k);
				end
			end
			run_j = any ? (XW'(j) - XW'(hu)) : (run_in + XW'(j + 1));
			hitv[j] = (run_j >= need);
			if (j == WORD_W - 1) begin
				run_out = run_j;
			end
		end
	end

	always_comb begin
		stat.hit     = |hitv;
		stat.hit_pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hitv[j]) begin
				stat.hit_pos = BIT_W'(j);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			mask[j] = (!first_row || (BIT_W'(j) >= lo_bit)) &&
				(!last_row || (BIT_W'(j) <= last_bit));
		end
		flips    = set_mode ? (mask & ~data) : (mask & data);
		new_word = set_mode ? (data | mask) : (data & ~mask);
		stat.pop = '0;
		for (int j = 0; j < WORD_W; j++) begin
			stat.pop = stat.pop + (BIT_W + 1)'(flips[j]);
		end
	end

endmodule

/* hdl/bitmap_page_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// first-fit physical page allocator over a used-page bitmap
// ----------------------------------------------------------------------------
// Requests arrive on req (action, page_index, page_count), one response per
// request leaves on rsp. cfg writes the search start (index 0) and the usable
// limit (index 1); it is always ready. It must be written only while idle;
// the block itself does not enforce this. The bitmap sits in a
// single-port-read RAM of 32 pages per row. Each row visit is a read state,
// then a check or a modify-and-write-back state. A query reads its row and
// checks the bit; a page at or beyond the limit answers without a read. A
// mark range reads and writes back each row touched, and answers without a
// read when nothing is marked. An alloc scans rows from the search start,
// then marks the run found; a failing alloc of zero pages or with the start
// at or beyond the limit answers without a scan.
// One request is worked on at a time; the next is taken once the response
// has moved into the output register, even if rsp is still stalled.
// After reset the RAM is swept to zero, row by row, with req.ready low. A
// stalled rsp holds the result and stops the engine at its end.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit
	import bpa_pkg::*;
#(
	parameter int NUM_PAGES = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp,
	bpa_cfg_if.sink   cfg
);

	localparam int AW   = $clog2(NUM_PAGES);
	localparam int XW   = ((AW > 17) ? AW : 17) + 1;
	localparam int CW   = AW + 1;
	localparam int ROWS = NUM_PAGES / WORD_W;
	localparam int RW   = $clog2(ROWS);
	localparam int QW   = XW - BIT_W;
	localparam logic [XW-1:0] NP_X = XW'(NUM_PAGES);

	bpa_state_t state_q, state_nxt;

	logic [15:0]    start_q;
	logic [16:0]    limit_q;
	logic [CW-1:0]  cnt_q;
	logic [RW-1:0]  clr_row_q;
	logic [QW-1:0]  row_q;
	logic [XW-1:0]  lo_q, hi_q, need_q, run_q;
	logic           set_q;
	logic [BIT_W-1:0] qbit_q;
	logic [15:0]    res_page_q;
	logic           res_ok_q, res_used_q;
	logic           out_valid_q;
	logic [15:0]    out_page_q;
	logic           out_ok_q, out_used_q;
	logic [16:0]    out_total_q;

	logic [XW-1:0]  lim_x, start_x, page_x, cnt_x, end_x, hi_x, lm1, hm1, word_base, rp;
	logic           accept, out_free;
	logic           rd_en, wr_en;
	logic [RW-1:0]  rd_addr, wr_addr;
	logic [WORD_W-1:0] rd_data, wr_data, new_word;
	logic [XW-1:0]  run_out;
	bpa_word_stat_t stat;
	bpa_action_t    act;
	logic           scan_last, mark_last;

	assign lim_x     = (XW'(limit_q) > NP_X) ? NP_X : XW'(limit_q);
	assign start_x   = XW'(start_q);
	assign page_x    = XW'(req.page_index);
	assign cnt_x     = XW'(req.page_count);
	assign end_x     = page_x + cnt_x;
	assign hi_x      = (end_x > NP_X) ? NP_X : end_x;
	assign lm1       = lim_x - XW'(1);
	assign hm1       = hi_q - XW'(1);
	assign word_base = {row_q, BIT_W'(0)};
	assign rp        = word_base + XW'(stat.hit_pos) + XW'(1) - need_q;
	assign scan_last = (row_q == lm1[XW-1:BIT_W]);
	assign mark_last = (row_q == hm1[XW-1:BIT_W]);
	assign act       = bpa_action_t'(req.action);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	bpa_bitmap_ram #(.ROWS(ROWS), .RW(RW)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bpa_word_ops #(.XW(XW)) u_ops (
		.data       (rd_data),
		.word_base  (word_base),
		.start_page (start_x),
		.lim_page   (lim_x),
		.run_in     (run_q),
		.need       (need_q),
		.set_mode   (set_q),
		.first_row  (row_q == lo_q[XW-1:BIT_W]),
		.last_row   (mark_last),
		.lo_bit     (lo_q[BIT_W-1:0]),
		.last_bit   (hm1[BIT_W-1:0]),
		.stat       (stat),
		.run_out    (run_out),
		.new_word   (new_word)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_row_q == RW'(ROWS - 1)) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (act)
						ACT_ALLOC: begin
							if (cnt_x == '0 || start_x >= lim_x) state_nxt = ST_DONE;
							else state_nxt = ST_SCAN_RD;
						end
						ACT_MARK_USED, ACT_MARK_FREE: begin
							if (page_x >= hi_x) state_nxt = ST_DONE;
							else state_nxt = ST_MARK_RD;
						end
						ACT_QUERY: begin
							if (page_x >= lim_x) state_nxt = ST_DONE;
							else state_nxt = ST_QRY_RD;
						end
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (stat.hit) state_nxt = ST_MARK_RD;
				else if (scan_last) state_nxt = ST_DONE;
				else state_nxt = ST_SCAN_RD;
			end
			ST_MARK_RD: state_nxt = ST_MARK_WR;
			ST_MARK_WR: state_nxt = mark_last ? ST_DONE : ST_MARK_RD;
			ST_QRY_RD:  state_nxt = ST_QRY_CHK;
			ST_QRY_CHK: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rd_en     = (state_q == ST_SCAN_RD) || (state_q == ST_MARK_RD) ||
			(state_q == ST_QRY_RD);
		rd_addr   = row_q[RW-1:0];
		wr_en     = (state_q == ST_CLEAR) || (state_q == ST_MARK_WR);
		wr_addr   = (state_q == ST_CLEAR) ? clr_row_q : row_q[RW-1:0];
		wr_data   = (state_q == ST_CLEAR) ? '0 : new_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			start_q     <= SEARCH_START_RST;
			limit_q     <= USABLE_LIMIT_RST;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) clr_row_q <= clr_row_q + RW'(1);
			if (cfg.valid && cfg.ready) begin
				case (bpa_cfg_reg_t'(cfg.reg_index))
					CFG_SEARCH_START: start_q <= cfg.wdata[15:0];
					CFG_USABLE_LIMIT: limit_q <= cfg.wdata;
					default: ;
				endcase
			end
			if (state_q == ST_MARK_WR) begin
				if (set_q) cnt_q <= cnt_q + CW'(stat.pop);
				else cnt_q <= cnt_q - CW'(stat.pop);
			end
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_page_q <= '0;
				res_ok_q   <= (act != ACT_ALLOC);
				res_used_q <= (act == ACT_QUERY) && (page_x >= lim_x);
				need_q     <= cnt_x;
				run_q      <= '0;
				lo_q       <= page_x;
				hi_q       <= hi_x;
				set_q      <= (act != ACT_MARK_FREE);
				qbit_q     <= req.page_index[BIT_W-1:0];
				row_q      <= (act == ACT_ALLOC) ? start_x[XW-1:BIT_W] : page_x[XW-1:BIT_W];
			end
			ST_SCAN_CHK: begin
				if (stat.hit) begin
					res_page_q <= rp[15:0];
					res_ok_q   <= 1'b1;
					lo_q       <= rp;
					hi_q       <= rp + need_q;
					row_q      <= rp[XW-1:BIT_W];
				end else begin
					run_q <= run_out;
					row_q <= row_q + QW'(1);
				end
			end
			ST_MARK_WR: row_q <= row_q + QW'(1);
			ST_QRY_CHK: res_used_q <= rd_data[qbit_q];
			ST_DONE: begin
				if (out_free) begin
					out_page_q  <= res_page_q;
					out_ok_q    <= res_ok_q;
					out_used_q  <= res_used_q;
					out_total_q <= 17'(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_page = out_page_q;
	assign rsp.success     = out_ok_q;
	assign rsp.page_used   = out_used_q;
	assign rsp.used_total  = out_total_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("engine stayed idle after a request transaction");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(NUM_PAGES) >= cnt_q)
		else $error("used page count exceeds the bitmap size");

	a_fail_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.success |-> rsp.result_page == 16'd0)
		else $error("failed alloc returned a nonzero page");

	a_no_ready_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready && !rsp.valid)
		else $error("request taken during the clearing sweep");

endmodule
